@@ rtl/core/jsonesc_pkg.sv @@
// ----------------------------------------------------------------------------
// jsonesc_pkg
// types, constants and helpers shared by the json string unescaper
// ----------------------------------------------------------------------------
package jsonesc_pkg;

    // escape phase of the decoder
    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESC    = 3'd1,
        PH_HEX1   = 3'd2,
        PH_HEX2   = 3'd3,
        PH_HEX3   = 3'd4,
        PH_HEX4   = 3'd5
    } phase_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_CR      = 8'h0D;

    // utf-8 lead and continuation marks
    localparam logic [7:0] UTF_LEAD2    = 8'hC0;
    localparam logic [7:0] UTF_LEAD3    = 8'hE0;
    localparam logic [7:0] UTF_CONT     = 8'h80;

    // result count of one item, 0 to 3
    typedef logic [1:0] cnt_t;

    // decoded results of one item plus the state it leaves
    typedef struct packed {
        cnt_t            cnt;
        logic [2:0][7:0] bytes;
        logic            byte_valid;
        logic            eos;
        phase_t          phase;
        logic [15:0]     acc;
    } dec_res_t;

    // non-hex digits count as zero
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

endpackage

@@ rtl/core/jsonesc_decode.sv @@
// ----------------------------------------------------------------------------
// jsonesc_decode
// single pass decode of one escaped byte against the escape state
// ----------------------------------------------------------------------------
module jsonesc_decode
(
    input  logic                  [7:0]  in_byte,
    input  logic                         last_of_string,
    input  jsonesc_pkg::phase_t          phase,
    input  logic                  [15:0] acc,
    output jsonesc_pkg::dec_res_t        res
);

    logic [15:0] cp;

    // code point with the new digit shifted in
    assign cp = {acc[11:0], jsonesc_pkg::hex_value(in_byte)};

    always_comb
    begin
        res            = '0;
        res.phase      = jsonesc_pkg::PH_NORMAL;
        res.acc        = acc;
        res.byte_valid = 1'b1;
        unique case (phase)
            jsonesc_pkg::PH_ESC:
            begin
                if (in_byte == jsonesc_pkg::CH_U)
                begin
                    res.phase = jsonesc_pkg::PH_HEX1;
                    res.acc   = 16'h0000;
                end
                else
                begin
                    res.cnt = 2'd1;
                    if (in_byte == jsonesc_pkg::CH_N)
                    begin
                        res.bytes[0] = jsonesc_pkg::BYTE_LF;
                    end
                    else if (in_byte == jsonesc_pkg::CH_T)
                    begin
                        res.bytes[0] = jsonesc_pkg::BYTE_TAB;
                    end
                    else if (in_byte == jsonesc_pkg::CH_R)
                    begin
                        res.bytes[0] = jsonesc_pkg::BYTE_CR;
                    end
                    else
                    begin
                        res.bytes[0] = in_byte;
                    end
                end
            end
            jsonesc_pkg::PH_HEX1, jsonesc_pkg::PH_HEX2, jsonesc_pkg::PH_HEX3:
            begin
                res.acc   = cp;
                res.phase = jsonesc_pkg::phase_t'(phase + 3'd1);
            end
            jsonesc_pkg::PH_HEX4:
            begin
                res.acc = 16'h0000;
                if (cp[15:7] == 9'd0)
                begin
                    res.cnt      = 2'd1;
                    res.bytes[0] = cp[7:0];
                end
                else if (cp[15:11] == 5'd0)
                begin
                    res.cnt      = 2'd2;
                    res.bytes[0] = jsonesc_pkg::UTF_LEAD2 | {3'b000, cp[10:6]};
                    res.bytes[1] = jsonesc_pkg::UTF_CONT | {2'b00, cp[5:0]};
                end
                else
                begin
                    res.cnt      = 2'd3;
                    res.bytes[0] = jsonesc_pkg::UTF_LEAD3 | {4'b0000, cp[15:12]};
                    res.bytes[1] = jsonesc_pkg::UTF_CONT | {2'b00, cp[11:6]};
                    res.bytes[2] = jsonesc_pkg::UTF_CONT | {2'b00, cp[5:0]};
                end
            end
            default:
            begin
                if (in_byte == jsonesc_pkg::CH_BACKSLASH)
                begin
                    res.phase = jsonesc_pkg::PH_ESC;
                end
                else
                begin
                    res.cnt      = 2'd1;
                    res.bytes[0] = in_byte;
                end
            end
        endcase

        // string end drops a pending escape, sends a bare marker if needed
        if (last_of_string)
        begin
            res.phase = jsonesc_pkg::PH_NORMAL;
            res.acc   = 16'h0000;
            res.eos   = 1'b1;
            if (res.cnt == 2'd0)
            begin
                res.cnt        = 2'd1;
                res.bytes[0]   = 8'h00;
                res.byte_valid = 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/json_escape_to_utf8_decoder_core.sv @@
// ----------------------------------------------------------------------------
// json_escape_to_utf8_decoder_core
// json string body unescaper with utf-8 output for backslash-u escapes
// ----------------------------------------------------------------------------
// usage
//   input channel: one raw byte of the string body per item, last_of_string
//   marks the final byte. output channel: one decoded byte per item, with
//   last_of_run on the final byte caused by an input item and end_of_string
//   on the final item of the string. a string end that yields no byte gives
//   a bare end marker (byte_valid low, out_byte zero). both channels are
//   valid/stall; an item moves when valid is high and stall is low.
// decode and throughput
//   an input item is decoded in the cycle it is accepted and its results
//   sit in the result buffer on the next cycle. plain bytes and simple
//   escapes run at one item per cycle while the receiver does not stall.
//   a backslash-u escape ends in up to three utf-8 bytes sent one per
//   cycle while the receiver does not stall, so the input stalls while the
//   result buffer drains. bytes that only advance the escape state
//   (backslash, 'u', first three hex digits) give no result.
// reset
//   escape state returns to normal with an empty accumulator, the result
//   buffer is emptied.
// receiver stall
//   the buffered result holds; the input stalls once the buffer cannot be
//   emptied in the same cycle.
// ----------------------------------------------------------------------------
module json_escape_to_utf8_decoder_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_of_string,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       end_of_string
);

    // escape state
    jsonesc_pkg::phase_t   phase_reg;
    logic [15:0]           acc_reg;

    // result buffer: bytes shift toward slot 0 as they leave
    jsonesc_pkg::cnt_t     cnt_reg;
    jsonesc_pkg::cnt_t     cnt_next;
    logic [2:0][7:0]       buf_reg;
    logic [2:0][7:0]       buf_next;
    logic                  bval_reg;
    logic                  eos_reg;

    jsonesc_pkg::dec_res_t dec;
    logic                  in_fire;
    logic                  out_fire;

    jsonesc_decode u_decode
    (
        .in_byte        (in_byte),
        .last_of_string (last_of_string),
        .phase          (phase_reg),
        .acc            (acc_reg),
        .res            (dec)
    );

    // accept while the buffer is empty or its last byte leaves this cycle
    assign in_stall = (cnt_reg > 2'd1) || ((cnt_reg == 2'd1) && out_stall);
    assign in_fire  = in_valid && !in_stall;

    assign out_valid     = (cnt_reg != 2'd0);
    assign out_fire      = out_valid && !out_stall;
    assign out_byte      = buf_reg[0];
    assign byte_valid    = bval_reg;
    assign last_of_run   = (cnt_reg == 2'd1);
    assign end_of_string = eos_reg && (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        buf_next = buf_reg;
        if (in_fire)
        begin
            cnt_next = dec.cnt;
            buf_next = dec.bytes;
        end
        else if (out_fire)
        begin
            cnt_next = jsonesc_pkg::cnt_t'(cnt_reg - 2'd1);
            buf_next = {8'h00, buf_reg[2], buf_reg[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsonesc_pkg::PH_NORMAL;
            acc_reg   <= 16'h0000;
            cnt_reg   <= 2'd0;
            bval_reg  <= 1'b0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                phase_reg <= dec.phase;
                acc_reg   <= dec.acc;
                bval_reg  <= dec.byte_valid;
                eos_reg   <= dec.eos;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

@@ rtl/core/jsonesc_checker.sv @@
// ----------------------------------------------------------------------------
// jsonesc_checker
// port level checks of the json unescaper, bound to the top level
// ----------------------------------------------------------------------------
module jsonesc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       last_of_run,
    input logic       end_of_string
);

    // a stalled result stays offered with the same byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("stalled result changed");

    // a bare marker only closes a string
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_string && out_byte == 8'h00)
        else $error("bare marker outside string end");

    // the string end is always the end of a run
    a_eos_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last_of_run)
        else $error("end of string inside a run");

    // input only waits behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // a run byte that leaves is followed by the rest of its run
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("run cut short");

endmodule

bind json_escape_to_utf8_decoder_core jsonesc_checker u_jsonesc_checker (.*);
